// ===== rtl/core/aar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aar_pkg
// Shared widths, constants, types and the arctangent table of the
// axis-angle rotation matrix pipeline.
// ----------------------------------------------------------------------------
package aar_pkg;

  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int OUT_FRAC_BITS_DEF = 14;
  localparam int ATAN_ENTRIES      = 24;

  localparam int ANG_W    = 16;
  localparam int AXIS_W   = 16;
  localparam int OUT_W    = 16;
  localparam int CW       = 34;
  localparam int SQ_W     = 31;
  localparam int N2_W     = 32;
  localparam int EXP_W    = 5;
  localparam int RAD_W    = 62;
  localparam int ROOT_W   = 31;
  localparam int SQ_REM_W = 35;
  localparam int UNIT_W   = 32;
  localparam int PROD_W   = 64;
  localparam int P_W      = 34;
  localparam int T_W      = 35;
  localparam int ENT_W    = 66;
  localparam int MAT_ENTRIES = 9;

  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int DIV_STEPS  = ROOT_W;
  localparam int NORM_LAT   = 4 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int MAT_LAT    = 4;

  localparam logic signed [CW-1:0] GAIN_Q30        = 34'sh26DD3B6A;
  localparam logic signed [CW-1:0] PI_Q30          = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30     = 34'sd1686629713;
  localparam logic signed [CW-1:0] NEG_HALF_PI_Q30 = -34'sd1686629713;
  localparam logic signed [CW-1:0] ONE_Q30         = 34'sd1073741824;

  typedef struct packed {
    logic                 valid;
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] s;
  } trig_t;

  typedef struct packed {
    logic                     valid;
    logic                     zero;
    logic signed [UNIT_W-1:0] ux;
    logic signed [UNIT_W-1:0] uy;
    logic signed [UNIT_W-1:0] uz;
  } unit_vec_t;

  typedef struct packed {
    logic                              valid;
    logic                              zero;
    logic [MAT_ENTRIES-1:0][OUT_W-1:0] ent;
  } matrix_t;

  function automatic logic signed [CW-1:0] atan_q30(input int idx);
    logic signed [CW-1:0] v;
    case (idx)
      0:  v = 34'sh3243F6A8;
      1:  v = 34'sh1DAC6705;
      2:  v = 34'sh0FADBAFC;
      3:  v = 34'sh07F56EA6;
      4:  v = 34'sh03FEAB76;
      5:  v = 34'sh01FFD55B;
      6:  v = 34'sh00FFFAAA;
      7:  v = 34'sh007FFF55;
      8:  v = 34'sh003FFFEA;
      9:  v = 34'sh001FFFFD;
      10: v = 34'sh000FFFFF;
      11: v = 34'sh0007FFFF;
      12: v = 34'sh0003FFFF;
      13: v = 34'sh0001FFFF;
      14: v = 34'sh0000FFFF;
      15: v = 34'sh00007FFF;
      16: v = 34'sh00003FFF;
      17: v = 34'sh00001FFF;
      18: v = 34'sh00000FFF;
      19: v = 34'sh000007FF;
      20: v = 34'sh000003FF;
      21: v = 34'sh000001FF;
      22: v = 34'sh000000FF;
      23: v = 34'sh0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/aar_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aar_cordic
// Pipelined rotation-mode cordic: angle reduction, one micro-rotation per
// stage, sign restore. Gives cosine and sine in Q4.30.
// ----------------------------------------------------------------------------
module aar_cordic #(
  parameter int CORDIC_STEPS = aar_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [aar_pkg::ANG_W-1:0]  angle_i,
  output aar_pkg::trig_t                    trig_o
);
  import aar_pkg::*;

  localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int LAT   = STEPS + 2;

  logic signed [CW-1:0] x_q [STEPS+1];
  logic signed [CW-1:0] y_q [STEPS+1];
  logic signed [CW-1:0] z_q [STEPS+1];
  logic                 flip_q [STEPS+1];
  logic [LAT-1:0]       val_q;
  logic signed [CW-1:0] c_q;
  logic signed [CW-1:0] s_q;
  logic signed [CW-1:0] ang_ext;

  assign ang_ext = CW'(angle_i) <<< 17;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= {val_q[LAT-2:0], valid_i};
    end
  end

  // quadrant fold
  always_ff @(posedge clk_i) begin
    x_q[0] <= GAIN_Q30;
    y_q[0] <= '0;
    if (ang_ext > HALF_PI_Q30) begin
      z_q[0]    <= ang_ext - PI_Q30;
      flip_q[0] <= 1'b1;
    end else if (ang_ext < NEG_HALF_PI_Q30) begin
      z_q[0]    <= ang_ext + PI_Q30;
      flip_q[0] <= 1'b1;
    end else begin
      z_q[0]    <= ang_ext;
      flip_q[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      flip_q[i+1] <= flip_q[i];
      if (!z_q[i][CW-1]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - atan_q30(i);
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + atan_q30(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= flip_q[STEPS] ? -x_q[STEPS] : x_q[STEPS];
    s_q <= flip_q[STEPS] ? -y_q[STEPS] : y_q[STEPS];
  end

  always_comb begin
    trig_o.valid = val_q[LAT-1];
    trig_o.c     = c_q;
    trig_o.s     = s_q;
  end

endmodule

// ===== rtl/core/aar_axis_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aar_axis_norm
// Pipelined axis normalizer: squared length, even normalizing shift,
// one root bit per stage square root, then one quotient bit per stage
// division of each component by the root. Gives the unit axis in Q2.30.
// ----------------------------------------------------------------------------
module aar_axis_norm (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [aar_pkg::AXIS_W-1:0] axis_x_i,
  input  logic signed [aar_pkg::AXIS_W-1:0] axis_y_i,
  input  logic signed [aar_pkg::AXIS_W-1:0] axis_z_i,
  output aar_pkg::unit_vec_t                vec_o
);
  import aar_pkg::*;

  typedef struct packed {
    logic                         zero;
    logic [2:0]                   neg;
    logic [2:0][AXIS_W-1:0]       mag;
    logic [EXP_W-1:0]             e;
  } side_t;

  logic [NORM_LAT-1:0] nv_q;

  logic signed [AXIS_W-1:0] ax [3];
  logic [SQ_W-1:0]          sq_q [3];
  side_t                    side_a_q, side_b_q, side_c_q;
  side_t                    side_c_d;
  logic [N2_W-1:0]          n2_q, n2c_q;
  logic [EXP_W-1:0]         msb;
  logic [EXP_W:0]           e_tmp;

  logic [RAD_W-1:0]    sn_q    [SQRT_STEPS+1];
  logic [SQ_REM_W-1:0] srem_q  [SQRT_STEPS+1];
  logic [ROOT_W-1:0]   sroot_q [SQRT_STEPS+1];
  side_t               sside_q [SQRT_STEPS+1];

  logic [RAD_W-1:0]  dvd [3];
  logic [ROOT_W-1:0] drem_q  [DIV_STEPS+1][3];
  logic [ROOT_W-1:0] dlow_q  [DIV_STEPS+1][3];
  logic [ROOT_W-1:0] dquo_q  [DIV_STEPS+1][3];
  logic [ROOT_W-1:0] droot_q [DIV_STEPS+1];
  side_t             dside_q [DIV_STEPS+1];

  logic                     zero_q;
  logic signed [UNIT_W-1:0] ux_q, uy_q, uz_q;

  assign ax[0] = axis_x_i;
  assign ax[1] = axis_y_i;
  assign ax[2] = axis_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= '0;
    end else begin
      nv_q <= {nv_q[NORM_LAT-2:0], valid_i};
    end
  end

  // squares and magnitudes
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      sq_q[l]         <= SQ_W'(32'(ax[l]) * 32'(ax[l]));
      side_a_q.neg[l] <= ax[l][AXIS_W-1];
      side_a_q.mag[l] <= ax[l][AXIS_W-1] ? AXIS_W'(-ax[l]) : AXIS_W'(ax[l]);
    end
    side_a_q.zero <= (axis_x_i == '0) && (axis_y_i == '0) && (axis_z_i == '0);
    side_a_q.e    <= '0;
  end

  always_ff @(posedge clk_i) begin
    n2_q     <= N2_W'(sq_q[0]) + N2_W'(sq_q[1]) + N2_W'(sq_q[2]);
    side_b_q <= side_a_q;
  end

  // leading one and even shift count
  always_comb begin
    msb = '0;
    for (int k = 0; k < N2_W; k++) begin
      if (n2_q[k]) begin
        msb = EXP_W'(k);
      end
    end
    e_tmp = 6'd61 - {1'b0, msb};
  end

  always_comb begin
    side_c_d   = side_b_q;
    side_c_d.e = e_tmp[EXP_W:1];
  end

  always_ff @(posedge clk_i) begin
    n2c_q    <= n2_q;
    side_c_q <= side_c_d;
  end

  always_ff @(posedge clk_i) begin
    sn_q[0]    <= RAD_W'(n2c_q) << {side_c_q.e, 1'b0};
    srem_q[0]  <= '0;
    sroot_q[0] <= '0;
    sside_q[0] <= side_c_q;
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;
    assign rem_sh = {srem_q[j][SQ_REM_W-3:0], sn_q[j][RAD_W-1-2*j -: 2]};
    assign trial  = SQ_REM_W'({sroot_q[j], 2'b01});
    always_ff @(posedge clk_i) begin
      sn_q[j+1]    <= sn_q[j];
      sside_q[j+1] <= sside_q[j];
      if (rem_sh >= trial) begin
        srem_q[j+1]  <= rem_sh - trial;
        sroot_q[j+1] <= {sroot_q[j][ROOT_W-2:0], 1'b1};
      end else begin
        srem_q[j+1]  <= rem_sh;
        sroot_q[j+1] <= {sroot_q[j][ROOT_W-2:0], 1'b0};
      end
    end
  end

  // dividend with half-root rounding term
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dvd[l] = (RAD_W'(sside_q[SQRT_STEPS].mag[l]) << (6'(sside_q[SQRT_STEPS].e) + 6'd30))
             + RAD_W'(sroot_q[SQRT_STEPS] >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      drem_q[0][l] <= dvd[l][RAD_W-1 -: ROOT_W];
      dlow_q[0][l] <= dvd[l][ROOT_W-1:0];
      dquo_q[0][l] <= '0;
    end
    droot_q[0] <= sroot_q[SQRT_STEPS];
    dside_q[0] <= sside_q[SQRT_STEPS];
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [ROOT_W:0] rem_sh;
      logic            ge;
      assign rem_sh = {drem_q[k-1][l], dlow_q[k-1][l][ROOT_W-k]};
      assign ge     = rem_sh >= {1'b0, droot_q[k-1]};
      always_ff @(posedge clk_i) begin
        dlow_q[k][l] <= dlow_q[k-1][l];
        dquo_q[k][l] <= {dquo_q[k-1][l][ROOT_W-2:0], ge};
        drem_q[k][l] <= ge ? ROOT_W'(rem_sh - {1'b0, droot_q[k-1]}) : rem_sh[ROOT_W-1:0];
      end
    end
    always_ff @(posedge clk_i) begin
      droot_q[k] <= droot_q[k-1];
      dside_q[k] <= dside_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= dside_q[DIV_STEPS].zero;
    ux_q   <= dside_q[DIV_STEPS].neg[0] ? -UNIT_W'(dquo_q[DIV_STEPS][0])
                                        : UNIT_W'(dquo_q[DIV_STEPS][0]);
    uy_q   <= dside_q[DIV_STEPS].neg[1] ? -UNIT_W'(dquo_q[DIV_STEPS][1])
                                        : UNIT_W'(dquo_q[DIV_STEPS][1]);
    uz_q   <= dside_q[DIV_STEPS].neg[2] ? -UNIT_W'(dquo_q[DIV_STEPS][2])
                                        : UNIT_W'(dquo_q[DIV_STEPS][2]);
  end

  always_comb begin
    vec_o.valid = nv_q[NORM_LAT-1];
    vec_o.zero  = zero_q;
    vec_o.ux    = ux_q;
    vec_o.uy    = uy_q;
    vec_o.uz    = uz_q;
  end

endmodule

// ===== rtl/core/aar_rodrigues.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aar_rodrigues
// Four-stage matrix assembly: outer products, scaling by one minus cosine,
// nine sums, then rounding, clamping and the identity override.
// ----------------------------------------------------------------------------
module aar_rodrigues #(
  parameter int OUT_FRAC_BITS = aar_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  aar_pkg::trig_t     trig_i,
  input  aar_pkg::unit_vec_t vec_i,
  output aar_pkg::matrix_t   mat_o
);
  import aar_pkg::*;

  localparam int SH = 60 - OUT_FRAC_BITS;
  localparam logic signed [ENT_W-1:0] RND     = 66'sd1 <<< (SH - 1);
  localparam logic signed [ENT_W-1:0] ONE_E   = 66'sd1 <<< OUT_FRAC_BITS;
  localparam logic signed [ENT_W-1:0] NEG_ONE = -ONE_E;
  localparam logic signed [ENT_W-1:0] OUT_MAX = 66'sd32767;
  localparam logic signed [ENT_W-1:0] OUT_MIN = -66'sd32768;
  localparam logic [OUT_W-1:0] ID_VAL =
    (OUT_FRAC_BITS >= 15) ? 16'd32767 : OUT_W'(1 << OUT_FRAC_BITS);

  function automatic logic signed [ENT_W-1:0] mul_tp(input logic signed [T_W-1:0] t,
                                                     input logic signed [P_W-1:0] p);
    return ENT_W'(t) * ENT_W'(p);
  endfunction

  function automatic logic [OUT_W-1:0] to_out(input logic signed [ENT_W-1:0] v);
    logic signed [ENT_W-1:0] r;
    r = (v + RND) >>> SH;
    if (r > ONE_E) r = ONE_E;
    if (r < NEG_ONE) r = NEG_ONE;
    if (r > OUT_MAX) r = OUT_MAX;
    if (r < OUT_MIN) r = OUT_MIN;
    return r[OUT_W-1:0];
  endfunction

  logic [MAT_LAT-1:0] v_q;
  logic [MAT_LAT-1:0] z_q;

  logic signed [PROD_W-1:0] pxx_q, pyy_q, pzz_q, pxy_q, pxz_q, pyz_q;
  logic signed [ENT_W-1:0]  xs_q, ys_q, zs_q, e0_q;
  logic signed [T_W-1:0]    t_q;

  logic signed [ENT_W-1:0]  txx_q, tyy_q, tzz_q, txy_q, txz_q, tyz_q;
  logic signed [ENT_W-1:0]  xs2_q, ys2_q, zs2_q, e02_q;

  logic signed [ENT_W-1:0]  ent_q [MAT_ENTRIES];
  logic [MAT_ENTRIES-1:0][OUT_W-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[MAT_LAT-2:0], vec_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    z_q   <= {z_q[MAT_LAT-2:0], vec_i.zero};
    pxx_q <= PROD_W'(vec_i.ux) * PROD_W'(vec_i.ux);
    pyy_q <= PROD_W'(vec_i.uy) * PROD_W'(vec_i.uy);
    pzz_q <= PROD_W'(vec_i.uz) * PROD_W'(vec_i.uz);
    pxy_q <= PROD_W'(vec_i.ux) * PROD_W'(vec_i.uy);
    pxz_q <= PROD_W'(vec_i.ux) * PROD_W'(vec_i.uz);
    pyz_q <= PROD_W'(vec_i.uy) * PROD_W'(vec_i.uz);
    xs_q  <= ENT_W'(vec_i.ux) * ENT_W'(trig_i.s);
    ys_q  <= ENT_W'(vec_i.uy) * ENT_W'(trig_i.s);
    zs_q  <= ENT_W'(vec_i.uz) * ENT_W'(trig_i.s);
    t_q   <= T_W'(ONE_Q30) - T_W'(trig_i.c);
    e0_q  <= ENT_W'(trig_i.c) <<< 30;
  end

  always_ff @(posedge clk_i) begin
    txx_q <= mul_tp(t_q, signed'(pxx_q[PROD_W-1:30]));
    tyy_q <= mul_tp(t_q, signed'(pyy_q[PROD_W-1:30]));
    tzz_q <= mul_tp(t_q, signed'(pzz_q[PROD_W-1:30]));
    txy_q <= mul_tp(t_q, signed'(pxy_q[PROD_W-1:30]));
    txz_q <= mul_tp(t_q, signed'(pxz_q[PROD_W-1:30]));
    tyz_q <= mul_tp(t_q, signed'(pyz_q[PROD_W-1:30]));
    xs2_q <= xs_q;
    ys2_q <= ys_q;
    zs2_q <= zs_q;
    e02_q <= e0_q;
  end

  always_ff @(posedge clk_i) begin
    ent_q[0] <= txx_q + e02_q;
    ent_q[1] <= txy_q + zs2_q;
    ent_q[2] <= txz_q - ys2_q;
    ent_q[3] <= txy_q - zs2_q;
    ent_q[4] <= tyy_q + e02_q;
    ent_q[5] <= tyz_q + xs2_q;
    ent_q[6] <= txz_q + ys2_q;
    ent_q[7] <= tyz_q - xs2_q;
    ent_q[8] <= tzz_q + e02_q;
  end

  // zero axis gives the identity
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAT_ENTRIES; k++) begin
      if (z_q[MAT_LAT-2]) begin
        out_q[k] <= (k % 4 == 0) ? ID_VAL : '0;
      end else begin
        out_q[k] <= to_out(ent_q[k]);
      end
    end
  end

  assign mat_o.valid = v_q[MAT_LAT-1];
  assign mat_o.zero  = z_q[MAT_LAT-1];
  assign mat_o.ent   = out_q;

endmodule

// ===== rtl/core/axis_angle_rotation_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Rotation matrix from an angle and an unnormalized axis, column-major.
// ----------------------------------------------------------------------------
// usage:
//   a transaction is taken on a rising edge with start_i high and busy_o
//   low; busy_o stays low, so one transaction can enter every cycle
//   angle_i is Q3.13 radians, axis_*_i are plain signed integers
//   each result appears on the col*_row*_o ports for one cycle with
//   valid_o high, after axis normalization and matrix assembly; the
//   cordic runs alongside and is delayed to match
//   throughput: one transaction per cycle, every stage fully pipelined
//   entries are Q2.14 by default; an all-zero axis raises zero_axis_o
//   and returns the identity matrix
//   reset clears all valid bits, so no result appears until a start
//   has passed through the pipeline; data in flight is dropped
//   the receiver cannot stall: a result is gone after its strobe cycle
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix #(
  parameter int CORDIC_STEPS  = aar_pkg::CORDIC_STEPS_DEF,
  parameter int OUT_FRAC_BITS = aar_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [aar_pkg::ANG_W-1:0]  angle_i,
  input  logic signed [aar_pkg::AXIS_W-1:0] axis_x_i,
  input  logic signed [aar_pkg::AXIS_W-1:0] axis_y_i,
  input  logic signed [aar_pkg::AXIS_W-1:0] axis_z_i,
  output logic                              valid_o,
  output logic signed [aar_pkg::OUT_W-1:0]  col0_row0_o,
  output logic signed [aar_pkg::OUT_W-1:0]  col0_row1_o,
  output logic signed [aar_pkg::OUT_W-1:0]  col0_row2_o,
  output logic signed [aar_pkg::OUT_W-1:0]  col1_row0_o,
  output logic signed [aar_pkg::OUT_W-1:0]  col1_row1_o,
  output logic signed [aar_pkg::OUT_W-1:0]  col1_row2_o,
  output logic signed [aar_pkg::OUT_W-1:0]  col2_row0_o,
  output logic signed [aar_pkg::OUT_W-1:0]  col2_row1_o,
  output logic signed [aar_pkg::OUT_W-1:0]  col2_row2_o,
  output logic                              zero_axis_o
);
  import aar_pkg::*;

  localparam int STEPS_EFF  = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int CORDIC_LAT = STEPS_EFF + 2;
  localparam int TRIG_DLY   = NORM_LAT - CORDIC_LAT;
  localparam logic signed [OUT_W-1:0] ONE_OUT =
    (OUT_FRAC_BITS >= 15) ? 16'sd32767 : OUT_W'(1 << OUT_FRAC_BITS);

  logic      accept;
  trig_t     trig;
  trig_t     trig_dly_q [TRIG_DLY];
  unit_vec_t norm_vec;
  matrix_t   mat;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  aar_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .angle_i (angle_i),
    .trig_o  (trig)
  );

  aar_axis_norm u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .axis_x_i (axis_x_i),
    .axis_y_i (axis_y_i),
    .axis_z_i (axis_z_i),
    .vec_o    (norm_vec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TRIG_DLY; k++) begin
        trig_dly_q[k] <= '0;
      end
    end else begin
      trig_dly_q[0] <= trig;
      for (int k = 1; k < TRIG_DLY; k++) begin
        trig_dly_q[k] <= trig_dly_q[k-1];
      end
    end
  end

  aar_rodrigues #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_rodrigues (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .trig_i (trig_dly_q[TRIG_DLY-1]),
    .vec_i  (norm_vec),
    .mat_o  (mat)
  );

  assign valid_o     = mat.valid;
  assign zero_axis_o = mat.zero;
  assign col0_row0_o = mat.ent[0];
  assign col0_row1_o = mat.ent[1];
  assign col0_row2_o = mat.ent[2];
  assign col1_row0_o = mat.ent[3];
  assign col1_row1_o = mat.ent[4];
  assign col1_row2_o = mat.ent[5];
  assign col2_row0_o = mat.ent[6];
  assign col2_row1_o = mat.ent[7];
  assign col2_row2_o = mat.ent[8];

  a_trig_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_vec.valid == trig_dly_q[TRIG_DLY-1].valid)
    else $error("cordic and axis paths out of step");

  a_zero_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && zero_axis_o |-> col0_row0_o == ONE_OUT && col1_row1_o == ONE_OUT &&
      col2_row2_o == ONE_OUT && col0_row1_o == '0 && col1_row2_o == '0 && col2_row0_o == '0)
    else $error("zero axis result is not the identity");

  a_diag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> col1_row1_o <= ONE_OUT &&
      (col1_row1_o >= -ONE_OUT || col1_row1_o == -16'sd32768))
    else $error("matrix entry outside unit range");

endmodule

// ===== sim/axis_angle_rotation_matrix_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_test
// Drives angle/axis transactions with random gaps and checks every matrix
// against a bit-exact predictor of the normalization, cordic and Rodrigues
// assembly, entry by entry, in order of issue.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_test;
  import aar_pkg::*;

  localparam int FRAC  = OUT_FRAC_BITS_DEF;
  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int LAT   = NORM_LAT + MAT_LAT;

  typedef struct packed {
    logic                 zero;
    logic [8:0][OUT_W-1:0] ent;
  } matrix_res_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic signed [ANG_W-1:0]  angle_i;
  logic signed [AXIS_W-1:0] axis_x_i, axis_y_i, axis_z_i;
  logic                     valid_o;
  logic signed [OUT_W-1:0]  c0r0, c0r1, c0r2, c1r0, c1r1, c1r2, c2r0, c2r1, c2r2;
  logic                     zero_axis_o;

  matrix_res_t expected_matrices[$];
  int          mismatches;

  longint atan_tab[24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

  axis_angle_rotation_matrix dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .angle_i(angle_i), .axis_x_i(axis_x_i), .axis_y_i(axis_y_i),
    .axis_z_i(axis_z_i), .valid_o(valid_o),
    .col0_row0_o(c0r0), .col0_row1_o(c0r1), .col0_row2_o(c0r2),
    .col1_row0_o(c1r0), .col1_row1_o(c1r1), .col1_row2_o(c1r2),
    .col2_row0_o(c2r0), .col2_row1_o(c2r1), .col2_row2_o(c2r2),
    .zero_axis_o(zero_axis_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic logic [OUT_W-1:0] round_entry(longint v60);
    longint r;
    r = (v60 + (64'sd1 <<< (59 - FRAC))) >>> (60 - FRAC);
    if (r > (64'sd1 <<< FRAC)) r = 64'sd1 <<< FRAC;
    if (r < -(64'sd1 <<< FRAC)) r = -(64'sd1 <<< FRAC);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[OUT_W-1:0];
  endfunction

  function automatic longint unit_of(longint v, int e, longint unsigned root);
    longint unsigned mag, q;
    mag = (v < 0) ? -v : v;
    q = ((mag << (30 + e)) + (root >> 1)) / root;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic matrix_res_t rotation_of(logic signed [15:0] ang,
                                              logic signed [15:0] ax,
                                              logic signed [15:0] ay,
                                              logic signed [15:0] az);
    matrix_res_t    m;
    longint         a, x, y, z, dx, dy, c, s, t, ux, uy, uz, e0;
    longint         pxx, pyy, pzz, pxy, pxz, pyz, xs, ys, zs;
    longint unsigned n2, n, root, bitv;
    int             e;
    bit             flip;
    m = '0;
    n2 = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
    if (n2 == 0) begin
      m.zero = 1'b1;
      m.ent[0] = round_entry(64'sd1 <<< 60);
      m.ent[4] = m.ent[0];
      m.ent[8] = m.ent[0];
      return m;
    end
    a = longint'(ang) * 131072;
    flip = 1'b0;
    if (a > 64'sd1686629713) begin
      a = a - 64'sd3373259426;
      flip = 1'b1;
    end else if (a < -64'sd1686629713) begin
      a = a + 64'sd3373259426;
      flip = 1'b1;
    end
    x = 64'h26DD3B6A;
    y = 0;
    z = a;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_tab[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    e = 0;
    while ((n2 << (2 * e)) < (64'd1 << 60)) e++;
    n = n2 << (2 * e);
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    ux = unit_of(ax, e, root);
    uy = unit_of(ay, e, root);
    uz = unit_of(az, e, root);
    t = (64'sd1 <<< 30) - c;
    pxx = (ux * ux) >>> 30; pyy = (uy * uy) >>> 30; pzz = (uz * uz) >>> 30;
    pxy = (ux * uy) >>> 30; pxz = (ux * uz) >>> 30; pyz = (uy * uz) >>> 30;
    xs = ux * s; ys = uy * s; zs = uz * s;
    e0 = c * (64'sd1 <<< 30);
    m.ent[0] = round_entry(t * pxx + e0);
    m.ent[1] = round_entry(t * pxy + zs);
    m.ent[2] = round_entry(t * pxz - ys);
    m.ent[3] = round_entry(t * pxy - zs);
    m.ent[4] = round_entry(t * pyy + e0);
    m.ent[5] = round_entry(t * pyz + xs);
    m.ent[6] = round_entry(t * pxz + ys);
    m.ent[7] = round_entry(t * pyz - xs);
    m.ent[8] = round_entry(t * pzz + e0);
    return m;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // checker
  always @(posedge clk_i) begin
    matrix_res_t exp_m;
    logic signed [OUT_W-1:0] got[9];
    if (rst_ni && valid_o) begin
      got = '{c0r0, c0r1, c0r2, c1r0, c1r1, c1r2, c2r0, c2r1, c2r2};
      if (expected_matrices.size() == 0) begin
        report("unexpected transaction", 1, 0);
      end else begin
        exp_m = expected_matrices.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[k] !== $signed(exp_m.ent[k]))
            report($sformatf("col%0d_row%0d", k / 3, k % 3), got[k],
                   $signed(exp_m.ent[k]));
        if (zero_axis_o !== exp_m.zero) report("zero_axis", zero_axis_o, exp_m.zero);
      end
    end
  end

  task automatic send_rotation(logic signed [15:0] ang, logic signed [15:0] ax,
                               logic signed [15:0] ay, logic signed [15:0] az);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk_i);
      start_i = 1'b0;
    end
    @(negedge clk_i);
    start_i  = 1'b1;
    angle_i  = ang;
    axis_x_i = ax;
    axis_y_i = ay;
    axis_z_i = az;
    do @(posedge clk_i); while (busy_o);
    expected_matrices.push_back(rotation_of(ang, ax, ay, az));
  endtask

  task automatic go_idle();
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  task automatic test_zero_axis();
    send_rotation(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_rotation(16'sd25736, 16'sd0, 16'sd0, 16'sd0);
    send_rotation(-16'sd32768, 16'sd0, 16'sd0, 16'sd0);
  endtask

  task automatic test_principal_axes();
    send_rotation(16'sd12868, 16'sd1, 16'sd0, 16'sd0);
    send_rotation(16'sd12868, 16'sd0, -16'sd7, 16'sd0);
    send_rotation(-16'sd12868, 16'sd0, 16'sd0, 16'sd32767);
    send_rotation(16'sd12867, 16'sd3, 16'sd4, 16'sd0);
    send_rotation(16'sd12869, -16'sd32768, 16'sd0, 16'sd0);
  endtask

  task automatic test_angle_extremes();
    send_rotation(16'sd25736, 16'sd1, 16'sd1, 16'sd1);
    send_rotation(-16'sd25736, -16'sd1, 16'sd2, -16'sd3);
    send_rotation(16'sd32767, 16'sd100, -16'sd200, 16'sd300);
    send_rotation(-16'sd32768, 16'sd5, 16'sd5, -16'sd5);
    send_rotation(16'sd0, 16'sd9, 16'sd8, 16'sd7);
    send_rotation(-16'sd1, 16'sd1, 16'sd0, 16'sd1);
  endtask

  task automatic test_axis_extremes();
    send_rotation(16'sd8000, -16'sd32768, -16'sd32768, -16'sd32768);
    send_rotation(-16'sd8000, 16'sd32767, 16'sd32767, 16'sd32767);
    send_rotation(16'sd20000, 16'sd32767, -16'sd32768, 16'sd1);
    send_rotation(16'sd3000, -16'sd1, -16'sd1, -16'sd1);
    send_rotation(16'sd25735, 16'sd1, 16'sd32767, 16'sd0);
  endtask

  task automatic wait_drained();
    while (expected_matrices.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_random(int count);
    logic signed [15:0] ang, v[3];
    for (int n = 0; n < count; n++) begin
      ang = ($urandom_range(0, 7) == 0) ? 16'($urandom)
            : 16'($urandom_range(0, 51472) - 25736);
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 5))
          0: v[k] = 16'($urandom_range(0, 16) - 8);
          1: v[k] = 0;
          default: v[k] = 16'($urandom);
        endcase
      end
      if ($urandom_range(0, 30) == 0) v = '{16'sd0, 16'sd0, 16'sd0};
      send_rotation(ang, v[0], v[1], v[2]);
      if (n == count / 2) begin
        go_idle();
        wait_drained();
      end
    end
  endtask

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    mismatches = 0;
    start_i  = 1'b0;
    angle_i  = '0;
    axis_x_i = '0;
    axis_y_i = '0;
    axis_z_i = '0;
    rst_ni   = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_zero_axis();
    test_principal_axes();
    test_angle_extremes();
    test_axis_extremes();
    test_random(750);
    go_idle();
    wait_drained();
    repeat (LAT + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
